@@ src/rnc_pkg.sv @@
// Roman numeral converter: shared types, constants and letter tables.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rnc_pkg;

    localparam int SumBitsDefault = 16;

    // Job queue between front and back
    localparam int JobDepth   = 2;
    localparam int JobPtrBits = $clog2(JobDepth);

    localparam logic [7:0] ChM = 8'h4D;
    localparam logic [7:0] ChD = 8'h44;
    localparam logic [7:0] ChC = 8'h43;
    localparam logic [7:0] ChL = 8'h4C;
    localparam logic [7:0] ChX = 8'h58;
    localparam logic [7:0] ChV = 8'h56;
    localparam logic [7:0] ChI = 8'h49;
    localparam logic [7:0] ChNone = 8'h00;

    localparam logic OpDecode = 1'b0;
    localparam logic OpEncode = 1'b1;

    localparam logic [13:0] Thousand = 14'd1000;
    localparam logic [13:0] NoMLimit = 14'd5000;

    typedef struct packed {
        logic        is_enc;
        logic [15:0] value;
        logic        sat;
    } t_job;

    typedef struct packed {
        logic [9:0] value;
        logic [7:0] first;
        logic [7:0] second;
        logic       two;
    } t_token;

    typedef enum logic [0:0] {
        B_IDLE,
        B_ENC
    } t_back_state;

    function automatic logic [9:0] letter_value(logic [7:0] c);
        logic [9:0] v;
        case (c)
            ChM:     v = 10'd1000;
            ChD:     v = 10'd500;
            ChC:     v = 10'd100;
            ChL:     v = 10'd50;
            ChX:     v = 10'd10;
            ChV:     v = 10'd5;
            ChI:     v = 10'd1;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // Subtractive pairs: CM CD XC XL IX IV
    function automatic logic is_subtractive(logic [7:0] c, logic [7:0] nx);
        return ((c == ChC) && ((nx == ChM) || (nx == ChD))) ||
               ((c == ChX) && ((nx == ChL) || (nx == ChC))) ||
               ((c == ChI) && ((nx == ChX) || (nx == ChV)));
    endfunction

    // Largest token not above r; r is nonzero and below 5000 here.
    function automatic t_token pick_token(logic [13:0] r);
        t_token t;
        if (r >= 14'd1000)     t = '{10'd1000, ChM, ChNone, 1'b0};
        else if (r >= 14'd900) t = '{10'd900,  ChC, ChM,    1'b1};
        else if (r >= 14'd500) t = '{10'd500,  ChD, ChNone, 1'b0};
        else if (r >= 14'd400) t = '{10'd400,  ChC, ChD,    1'b1};
        else if (r >= 14'd100) t = '{10'd100,  ChC, ChNone, 1'b0};
        else if (r >= 14'd90)  t = '{10'd90,   ChX, ChC,    1'b1};
        else if (r >= 14'd50)  t = '{10'd50,   ChL, ChNone, 1'b0};
        else if (r >= 14'd40)  t = '{10'd40,   ChX, ChL,    1'b1};
        else if (r >= 14'd10)  t = '{10'd10,   ChX, ChNone, 1'b0};
        else if (r >= 14'd9)   t = '{10'd9,    ChI, ChX,    1'b1};
        else if (r >= 14'd5)   t = '{10'd5,    ChV, ChNone, 1'b0};
        else if (r >= 14'd4)   t = '{10'd4,    ChI, ChV,    1'b1};
        else                   t = '{10'd1,    ChI, ChNone, 1'b0};
        return t;
    endfunction

endpackage

@@ src/rnc_job_fifo.sv @@
// Two-entry job queue between the front and the back of the converter.
// Depends on rnc_pkg (t_job, JobDepth).
`timescale 1ns / 1ps

module rnc_job_fifo import rnc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job                  r_slot [JobDepth];
    logic [JobPtrBits-1:0] r_wr_ptr, r_rd_ptr;
    logic [JobPtrBits:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == JobPtrBits'(JobDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == JobPtrBits'(JobDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (JobPtrBits + 1)'(JobDepth));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from an empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count did not follow a push");

endmodule

@@ src/rnc_front.sv @@
// Front of the converter: takes items, runs the Roman decode accumulator,
// and posts finished decode sums and encode requests as jobs. Depends on rnc_pkg.
`timescale 1ns / 1ps

module rnc_front import rnc_pkg::*; #(
    parameter int SUM_BITS = SumBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_character,
    input  logic [13:0] i_number,
    input  logic        i_last_char,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_job        o_push_job
);

    // One sign bit for the transient dip, one carry bit above the maximum
    localparam int SW = SUM_BITS + 2;
    localparam logic signed [SW-1:0] SumMax = {2'b00, {SUM_BITS{1'b1}}};

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic                 sat;
    } t_acc;

    function automatic t_acc resolve(t_acc a, logic [7:0] c, logic sub);
        t_acc                 res;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] t;
        res = a;
        v   = {{(SW-10){1'b0}}, letter_value(c)};
        t   = a.sum + v;
        if (!a.sat) begin
            if (sub) begin
                res.sum = a.sum - v;
            end else if (t > SumMax) begin
                res.sum = SumMax;
                res.sat = 1'b1;
            end else begin
                res.sum = t;
            end
        end
        return res;
    endfunction

    logic [7:0]           r_pend_char, n_pend_char;
    logic                 r_pend_valid, n_pend_valid;
    logic signed [SW-1:0] r_sum, n_sum;
    logic                 r_sat, n_sat;

    t_acc                  acc_held, acc_ahead, acc_final;
    logic [SUM_BITS-1:0]   clipped;
    logic                  accept;

    // A decode item that is not last posts nothing, so it never waits on the queue
    assign o_in_ready = !i_queue_full || ((i_operation == OpDecode) && !i_last_char);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        acc_held  = '{r_sum, r_sat};
        acc_ahead = r_pend_valid
                  ? resolve(acc_held, r_pend_char, is_subtractive(r_pend_char, i_character))
                  : acc_held;
        acc_final = resolve(acc_ahead, i_character, 1'b0);
        clipped   = acc_final.sum[SW-1] ? '0 : acc_final.sum[SUM_BITS-1:0];
    end

    always_comb begin
        n_pend_char  = r_pend_char;
        n_pend_valid = r_pend_valid;
        n_sum        = r_sum;
        n_sat        = r_sat;
        o_push       = 1'b0;
        o_push_job   = '{OpEncode, {2'b00, i_number}, 1'b0};
        if (accept) begin
            if (i_operation == OpEncode) begin
                o_push = 1'b1;
            end else if (i_last_char) begin
                o_push       = 1'b1;
                o_push_job   = '{OpDecode, 16'(clipped), acc_final.sat};
                n_pend_char  = '0;
                n_pend_valid = 1'b0;
                n_sum        = '0;
                n_sat        = 1'b0;
            end else begin
                n_pend_char  = i_character;
                n_pend_valid = 1'b1;
                n_sum        = acc_ahead.sum;
                n_sat        = acc_ahead.sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_char  <= '0;
            r_pend_valid <= 1'b0;
            r_sum        <= '0;
            r_sat        <= 1'b0;
        end else begin
            r_pend_char  <= n_pend_char;
            r_pend_valid <= n_pend_valid;
            r_sum        <= n_sum;
            r_sat        <= n_sat;
        end
    end

endmodule

@@ src/rnc_back.sv @@
// Back of the converter: drains jobs, returns decode sums and spells encode
// numbers one Roman letter per result, into a registered output. Depends on rnc_pkg.
`timescale 1ns / 1ps

module rnc_back import rnc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_roman_char,
    output logic        o_char_valid,
    output logic [15:0] o_arabic_value,
    output logic        o_saturated,
    output logic        o_last_result
);

    t_back_state r_state, n_state;

    logic [13:0] r_num, n_num;
    logic [13:0] r_rem, n_rem;
    logic        r_big, n_big;
    logic        r_pend2, n_pend2;
    logic [7:0]  r_char2, n_char2;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_char, n_out_char;
    logic        r_out_cv, n_out_cv;
    logic [15:0] r_out_value, n_out_value;
    logic        r_out_sat, n_out_sat;
    logic        r_out_last, n_out_last;

    logic        slot_free;
    t_token      tok;
    logic [13:0] rem_after;
    logic        silent_m;

    assign slot_free = !r_out_valid || i_out_ready;
    assign tok       = pick_token(r_rem);
    assign rem_after = r_rem - {4'd0, tok.value};
    // Thousands above four: strip them without a letter
    assign silent_m  = r_big && (r_rem >= Thousand);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty && i_head.is_enc) begin
                    n_state = B_ENC;
                end
            end
            B_ENC: begin
                if (r_pend2) begin
                    if (slot_free && (r_rem == '0)) n_state = B_IDLE;
                end else if (r_rem == '0) begin
                    if (slot_free) n_state = B_IDLE;
                end else if (!silent_m) begin
                    if (slot_free && !tok.two && (rem_after == '0)) n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_num       = r_num;
        n_rem       = r_rem;
        n_big       = r_big;
        n_pend2     = r_pend2;
        n_char2     = r_char2;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_cv    = r_out_cv;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_head.is_enc) begin
                        o_pop   = 1'b1;
                        n_num   = i_head.value[13:0];
                        n_rem   = i_head.value[13:0];
                        n_big   = (i_head.value[13:0] >= NoMLimit);
                        n_pend2 = 1'b0;
                    end else if (slot_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_char  = ChNone;
                        n_out_cv    = 1'b0;
                        n_out_value = i_head.value;
                        n_out_sat   = i_head.sat;
                        n_out_last  = 1'b1;
                    end
                end
            end
            B_ENC: begin
                // a result still waiting keeps its payload
                if (slot_free) begin
                    n_out_value = {2'b00, r_num};
                    n_out_sat   = 1'b0;
                end
                if (r_pend2) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_char  = r_char2;
                        n_out_cv    = 1'b1;
                        n_out_last  = (r_rem == '0);
                        n_pend2     = 1'b0;
                    end
                end else if (r_rem == '0) begin
                    // Nothing was spelt: one empty result
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_char  = ChNone;
                        n_out_cv    = 1'b0;
                        n_out_last  = 1'b1;
                    end
                end else if (silent_m) begin
                    n_rem = r_rem - Thousand;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = tok.first;
                    n_out_cv    = 1'b1;
                    n_out_last  = !tok.two && (rem_after == '0);
                    n_rem       = rem_after;
                    n_pend2     = tok.two;
                    n_char2     = tok.second;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pend2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend2     <= n_pend2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_big       <= n_big;
        r_char2     <= n_char2;
        r_out_char  <= n_out_char;
        r_out_cv    <= n_out_cv;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_roman_char   = r_out_char;
    assign o_char_valid   = r_out_cv;
    assign o_arabic_value = r_out_value;
    assign o_saturated    = r_out_sat;
    assign o_last_result  = r_out_last;

endmodule

@@ src/roman_numeral_converter_unit.sv @@
// Roman numeral converter, top level: front, two-entry job queue, back.
// Depends on rnc_pkg, rnc_front, rnc_job_fifo and rnc_back.
`timescale 1ns / 1ps

// Each item picks its mode. Decode (operation 0) takes one Roman character per
// item and per cycle; the front holds one character back as look-ahead, so
// CM/CD/XC/XL/IX/IV subtract, and the item marked last_char yields a single
// result carrying the sum (clipped at 2^SUM_BITS-1 with the saturated flag; the
// low 16 bits are shown). Non-final characters give no result. Encode
// (operation 1) takes a number and yields its letters one per result, in
// order, last_result on the final one; thousands above four spell no M, and a
// number that spells nothing gives one result with char_valid low. An encode
// in the middle of a string leaves the decode state alone.
// Rate: a decode character is taken every cycle, but a final one waits while
// the queue is full; a finished decode sum or an encode request goes into a
// two-entry job queue, and the back side drains it. The back returns at most
// one result per cycle, and none while the receiver holds it off: a decode sum
// gives one result; an encode is loaded, strips each thousand silently when the
// number is 5000 or more (up to 16), then gives one result per letter (at most
// 16, or one empty result). Input is held off only while the job queue is full.

module roman_numeral_converter_unit import rnc_pkg::*; #(
    parameter int SUM_BITS = SumBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_character,
    input  logic [13:0] i_number,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_roman_char,
    output logic        o_char_valid,
    output logic [15:0] o_arabic_value,
    output logic        o_saturated,
    output logic        o_last_result
);

    logic push, pop, queue_empty, queue_full;
    t_job push_job, head_job;

    // Front: decode accumulator and job posting
    rnc_front #(
        .SUM_BITS(SUM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_character (i_character),
        .i_number    (i_number),
        .i_last_char (i_last_char),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_push_job  (push_job)
    );

    // Queue lets the front run on while the back spells a long number
    rnc_job_fifo u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_job(push_job),
        .i_pop     (pop),
        .o_head    (head_job),
        .o_empty   (queue_empty),
        .o_full    (queue_full)
    );

    // Back: letter sequencer and registered output
    rnc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_job),
        .i_empty       (queue_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_roman_char  (o_roman_char),
        .o_char_valid  (o_char_valid),
        .o_arabic_value(o_arabic_value),
        .o_saturated   (o_saturated),
        .o_last_result (o_last_result)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for roman_numeral_converter_unit: decode and encode items,
// predicted in-bench and compared result by result. Depends on rnc_pkg and the unit.
`timescale 1ns / 1ps

module testbench;
    import rnc_pkg::*;

    localparam int SumMax     = (1 << SumBitsDefault) - 1;
    localparam int StallLimit = 2000;   // cycles with no item moving on either side
    localparam int DrainWait  = 40;     // settling time after the last result
    localparam int RandItems  = 450;
    localparam int MaxPrinted = 60;

    // One output item, in port order
    typedef struct packed {
        logic [7:0]  roman;
        logic        cvalid;
        logic [15:0] value;
        logic        sat;
        logic        last;
    } t_conv_result;

    // Letters of one encoded number, first letter at index 0
    typedef struct packed {
        logic [4:0]       count;
        logic [15:0][7:0] letters;
    } t_spelling;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [7:0]  i_character;
    logic [13:0] i_number;
    logic        i_last_char;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_roman_char;
    logic        o_char_valid;
    logic [15:0] o_arabic_value;
    logic        o_saturated;
    logic        o_last_result;

    roman_numeral_converter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_character    (i_character),
        .i_number       (i_number),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_roman_char   (o_roman_char),
        .o_char_valid   (o_char_valid),
        .o_arabic_value (o_arabic_value),
        .o_saturated    (o_saturated),
        .o_last_result  (o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted decoder state and the queue of results still owed
    // ------------------------------------------------------------------
    logic [7:0]   held_char;
    logic         held_valid;
    int           run_sum;      // signed: a subtracting pair can dip it below zero
    logic         run_sat;
    t_conv_result results_due[$];

    int           error_count;
    int           result_count;
    int           items_sent;
    int           idle_cycles;

    // Sender burst bookkeeping
    int           burst_left;
    int           gap_len;

    // Receiver stall pattern
    int unsigned  rx_cycle;
    int           rx_stalled;

    task report_error(input string msg);
        begin
            if (error_count < MaxPrinted)
                $display("ERROR @%0t: %s", $realtime, msg);
            error_count = error_count + 1;
        end
    endtask

    function automatic int letter_worth(input logic [7:0] c);
        case (c)
            ChM:     return 1000;
            ChD:     return 500;
            ChC:     return 100;
            ChL:     return 50;
            ChX:     return 10;
            ChV:     return 5;
            ChI:     return 1;
            default: return 0;
        endcase
    endfunction

    function automatic t_conv_result make_result(input logic [7:0] roman, input logic cvalid,
                                                 input logic [15:0] value, input logic sat,
                                                 input logic last);
        t_conv_result r;
        r.roman  = roman;
        r.cvalid = cvalid;
        r.value  = value;
        r.sat    = sat;
        r.last   = last;
        return r;
    endfunction

    function automatic t_spelling push_letter(input t_spelling s, input logic [7:0] c);
        t_spelling r;
        r = s;
        r.letters[r.count] = c;
        r.count = r.count + 5'd1;
        return r;
    endfunction

    // One decimal digit in the one/five/ten scheme
    function automatic t_spelling add_digit(input t_spelling s, input int d,
                                            input logic [7:0] one, input logic [7:0] five,
                                            input logic [7:0] ten);
        t_spelling r;
        r = s;
        if (d >= 1 && d <= 3) begin
            for (int i = 0; i < d; i++) r = push_letter(r, one);
        end else if (d == 4) begin
            r = push_letter(r, one);
            r = push_letter(r, five);
        end else if (d >= 5 && d <= 8) begin
            r = push_letter(r, five);
            for (int i = 5; i < d; i++) r = push_letter(r, one);
        end else if (d == 9) begin
            r = push_letter(r, one);
            r = push_letter(r, ten);
        end
        return r;
    endfunction

    // Thousands digit above four spells no M at all
    function automatic t_spelling spell_number(input logic [13:0] n);
        t_spelling s;
        int thou;
        int rest;
        s    = '0;
        thou = n / 1000;
        rest = n % 1000;
        if (thou >= 1 && thou <= 4)
            for (int i = 0; i < thou; i++) s = push_letter(s, ChM);
        s = add_digit(s, rest / 100, ChC, ChD, ChM);
        s = add_digit(s, (rest % 100) / 10, ChX, ChL, ChC);
        s = add_digit(s, rest % 10, ChI, ChV, ChX);
        return s;
    endfunction

    task clear_decoder;
        begin
            held_char  = ChNone;
            held_valid = 1'b0;
            run_sum    = 0;
            run_sat    = 1'b0;
        end
    endtask

    // Fold one letter into the sum; nx is its look-ahead when has_next is set
    task settle_letter(input logic [7:0] c, input logic has_next, input logic [7:0] nx);
        int   worth;
        logic minus;
        begin
            worth = letter_worth(c);
            minus = has_next &&
                    ((c == ChC && (nx == ChM || nx == ChD)) ||
                     (c == ChX && (nx == ChL || nx == ChC)) ||
                     (c == ChI && (nx == ChX || nx == ChV)));
            // once clipped, nothing moves the sum until the string ends
            if (!run_sat) begin
                if (minus) begin
                    run_sum = run_sum - worth;
                end else begin
                    run_sum = run_sum + worth;
                    if (run_sum > SumMax) begin
                        run_sum = SumMax;
                        run_sat = 1'b1;
                    end
                end
            end
        end
    endtask

    task predict_item(input logic op, input logic [7:0] ch, input logic [13:0] num,
                      input logic last);
        t_spelling   sp;
        logic [15:0] shown;
        begin
            if (op == OpDecode) begin
                if (held_valid)
                    settle_letter(held_char, 1'b1, ch);
                if (!last) begin
                    held_char  = ch;
                    held_valid = 1'b1;
                end else begin
                    settle_letter(ch, 1'b0, ChNone);
                    shown = (run_sum < 0) ? 16'd0 : run_sum[15:0];
                    results_due.push_back(make_result(ChNone, 1'b0, shown, run_sat, 1'b1));
                    clear_decoder();
                end
            end else begin
                // encode leaves the decoder untouched
                sp = spell_number(num);
                if (sp.count == 0) begin
                    results_due.push_back(make_result(ChNone, 1'b0, {2'b00, num}, 1'b0, 1'b1));
                end else begin
                    for (int k = 0; k < sp.count; k++)
                        results_due.push_back(make_result(sp.letters[k], 1'b1, {2'b00, num},
                                                          1'b0, k == sp.count - 1));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: inputs are predicted as accepted, outputs checked as taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_conv_result got;
        t_conv_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_item(i_operation, i_character, i_number, i_last_char);
            if (o_out_valid && i_out_ready) begin
                got.roman  = o_roman_char;
                got.cvalid = o_char_valid;
                got.value  = o_arabic_value;
                got.sat    = o_saturated;
                got.last   = o_last_result;
                if (results_due.size() == 0) begin
                    report_error($sformatf("unexpected result %0d: %h", result_count, got));
                end else begin
                    want = results_due.pop_front();
                    if (got.roman !== want.roman)
                        report_error($sformatf("result %0d roman_char %02h, want %02h",
                                               result_count, got.roman, want.roman));
                    if (got.cvalid !== want.cvalid)
                        report_error($sformatf("result %0d char_valid %b, want %b",
                                               result_count, got.cvalid, want.cvalid));
                    if (got.value !== want.value)
                        report_error($sformatf("result %0d arabic_value %0d, want %0d",
                                               result_count, got.value, want.value));
                    if (got.sat !== want.sat)
                        report_error($sformatf("result %0d saturated %b, want %b",
                                               result_count, got.sat, want.sat));
                    if (got.last !== want.last)
                        report_error($sformatf("result %0d last_result %b, want %b",
                                               result_count, got.last, want.last));
                end
                result_count = result_count + 1;
            end
        end
    end

    // Watchdog: too long with nothing moving means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles == StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: rotates through always-ready, light, periodic and heavy stalling
    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        case ((rx_cycle / 150) % 4)
            0: begin
                i_out_ready = 1'b1;
            end
            1: begin
                i_out_ready = ($urandom_range(0, 9) < 7);
            end
            2: begin
                i_out_ready = ((rx_cycle % 5) != 0) && ((rx_cycle % 7) != 3);
            end
            default: begin
                i_out_ready = ($urandom_range(0, 9) < 3) || (rx_stalled >= 12);
            end
        endcase
        rx_stalled = i_out_ready ? 0 : rx_stalled + 1;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drives one item at a falling edge and holds it until it is taken.
    // Bursts of random length, with random gaps (often none) between them.
    task send_item(input logic op, input logic [7:0] ch, input logic [13:0] num,
                   input logic last);
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                gap_len = 0;
            end
            burst_left = burst_left - 1;
            @(negedge i_clk);
            if (gap_len > 0) begin
                i_in_valid = 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
            i_in_valid  = 1'b1;
            i_operation = op;
            i_character = ch;
            i_number    = num;
            i_last_char = last;
            do @(posedge i_clk); while (!o_in_ready);
            items_sent = items_sent + 1;
        end
    endtask

    // Decode character; the unused number field gets noise
    task send_char(input logic [7:0] ch, input logic last);
        send_item(OpDecode, ch, 14'($urandom_range(0, 16383)), last);
    endtask

    // Encode item; the unused character and last mark get noise
    task send_number(input logic [13:0] num);
        send_item(OpEncode, 8'($urandom_range(0, 255)), num, 1'($urandom_range(0, 1)));
    endtask

    task send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // Well-formed numeral for n (1..4999), sometimes with an encode slipped in mid-string
    task send_roman(input logic [13:0] n);
        t_spelling sp;
        begin
            sp = spell_number(n);
            for (int i = 0; i < sp.count; i++) begin
                if (i > 0 && $urandom_range(0, 9) == 0)
                    send_number(14'($urandom_range(0, 9999)));
                send_char(sp.letters[i], i == sp.count - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task test_encode_extremes;
        begin
            send_number(14'd0);         // empty encoding
            send_number(14'd1);
            send_number(14'd4888);      // longest spelling, 16 letters
            send_number(14'd4999);      // subtractive pairs CM, XC and IX
            send_number(14'd5000);      // thousands above four: nothing left to spell
            send_number(14'd9999);
            send_number(14'd16383);     // top of the field
            send_number(14'd8192);
            send_number(14'd1994);
        end
    endtask

    task test_decode_pairs;
        begin
            send_text("MCMXCIV");       // CM, XC, IV
            send_text("CDXLIX");        // CD, XL, IX; sum dips below zero first
            send_text("I");             // lone final character
            send_char(ChI, 1'b0);       // other bytes add nothing but still look ahead
            send_char(8'h00, 1'b0);
            send_char(ChV, 1'b0);
            send_char(8'hFF, 1'b1);
            send_char(ChX, 1'b0);       // encode in the middle of a string
            send_number(14'd42);
            send_char(ChC, 1'b1);
        end
    endtask

    task test_saturation;
        begin
            // 66 thousands pass the 16-bit limit; the trailing IX must not pull it back
            for (int i = 0; i < 66; i++) send_char(ChM, 1'b0);
            send_text("IX");
            send_text("V");             // flag cleared for the next string
        end
    endtask

    task test_random_mix;
        string letters;
        int    pick;
        int    len;
        begin
            letters = "MDCLXVI";
            while (items_sent < RandItems) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_roman(14'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4999)
                                                                : $urandom_range(1, 3999)));
                end else if (pick < 65) begin
                    // letters in any order
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_char(letters[$urandom_range(0, 6)], i == len - 1);
                end else if (pick < 72) begin
                    // arbitrary bytes, letters among them now and then
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        send_char(($urandom_range(0, 3) == 0) ? letters[$urandom_range(0, 6)]
                                                             : 8'($urandom_range(0, 255)),
                                  i == len - 1);
                end else if (pick < 99) begin
                    send_number(14'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                               : $urandom_range(0, 9999)));
                end else begin
                    // long run of thousands, reaching the clip point or just short of it
                    len = $urandom_range(60, 70);
                    for (int i = 0; i < len; i++)
                        send_char(($urandom_range(0, 7) == 0) ? letters[$urandom_range(0, 6)]
                                                             : ChM, i == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OpDecode;
        i_character  = ChNone;
        i_number     = '0;
        i_last_char  = 1'b0;
        i_out_ready  = 1'b0;
        error_count  = 0;
        result_count = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gap_len      = 0;
        rx_cycle     = 0;
        rx_stalled   = 0;
        clear_decoder();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_encode_extremes();
        test_decode_pairs();
        test_saturation();
        test_random_mix();

        @(negedge i_clk);
        i_in_valid = 1'b0;

        // the watchdog covers results that never turn up
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ roman_numeral_converter_unit.f @@
src/rnc_pkg.sv
src/rnc_job_fifo.sv
src/rnc_front.sv
src/rnc_back.sv
src/roman_numeral_converter_unit.sv
tb/testbench.sv
